FILE: hw/rtl/stp_pkg.sv
// Shared types and codes for the software timer pool.
package stp_pkg;

    localparam int STP_SLOTS = 16;
    localparam int MS_W      = 24;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    localparam logic [1:0] KIND_ADDED = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_NEXT  = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]      action;
        logic [MS_W-1:0] interval_ms;
        logic            one_shot;
        logic [3:0]      slot_id;
    } stp_in_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [3:0]      slot;
        logic [MS_W-1:0] remaining_ms;
        logic            any_active;
        logic            last;
    } stp_out_t;

    typedef struct packed {
        logic [MS_W-1:0] interval;
        logic [MS_W-1:0] remaining;
    } slot_entry_t;

endpackage

FILE: hw/rtl/stp_slot_mem.sv
// Slot timing memory: interval and remaining time, one write and one registered read port.
module stp_slot_mem #(
    parameter int SLOTS = stp_pkg::STP_SLOTS,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  stp_pkg::slot_entry_t wdata,
    input  logic [IDX_W-1:0]     raddr,
    output stp_pkg::slot_entry_t rdata
);
    import stp_pkg::*;

    slot_entry_t mem [SLOTS];
    slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/stp_free_find.sv
// Lowest free slot search over the active flags.
module stp_free_find #(
    parameter int SLOTS = stp_pkg::STP_SLOTS,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOTS-1:0] active,
    output logic             found,
    output logic [IDX_W-1:0] idx
);
    import stp_pkg::*;

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

FILE: hw/rtl/software_timer_pool.sv
// Timer pool top level: command sequencer, slot flags and output register.
// Add: the result is registered from the add state once the output is free; delete: done at accept, no result.
// Tick and query walk the slot memory one slot per cycle unless a fired result waits on a
// stalled output; the single read port of the slot memory sets that pace.
// Reset (rst_n, async) clears all slot flags, so the pool starts empty; the
// slot memory is not cleared, only the contents of active slots are ever used.
module software_timer_pool #(
    parameter int SLOTS = stp_pkg::STP_SLOTS,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  stp_pkg::stp_in_t cmd,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output stp_pkg::stp_out_t rsp
);
    import stp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ADD   = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    stp_in_t          cmd_reg, cmd_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic [SLOTS-1:0] one_shot_reg, one_shot_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_slot_reg, pend_slot_next;
    logic             any_reg, any_next;
    logic [MS_W-1:0]  best_reg, best_next;
    logic             rsp_valid_reg, rsp_valid_next;
    stp_out_t         rsp_reg, rsp_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_entry_t      mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    slot_entry_t      mem_rdata;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;

    logic out_free;
    logic is_tick;
    logic cur_act;
    logic fire;
    logic adv;
    logic last_idx;

    stp_slot_mem #(.SLOTS(SLOTS)) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    stp_free_find #(.SLOTS(SLOTS)) u_free_find (
        .active (active_reg),
        .found  (free_found),
        .idx    (free_idx)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign is_tick  = (cmd_reg.action == ACT_TICK);
    assign cur_act  = active_reg[idx_reg];
    assign fire     = is_tick && cur_act && (mem_rdata.remaining <= MS_W'(1));
    assign adv      = !(fire && pend_valid_reg && !out_free);
    assign last_idx = (idx_reg == IDX_W'(SLOTS - 1));

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        active_next     = active_reg;
        one_shot_next   = one_shot_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        any_next        = any_reg;
        best_next       = best_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    case (cmd.action)
                        ACT_ADD:
                        begin
                            state_next = ST_ADD;
                        end
                        ACT_DELETE:
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (32'(cmd.slot_id) == i)
                                begin
                                    active_next[i] = 1'b0;
                                end
                            end
                        end
                        ACT_TICK, ACT_QUERY:
                        begin
                            state_next      = ST_WALK;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            any_next        = 1'b0;
                            best_next       = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                if (out_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next              = '0;
                    rsp_next.last         = 1'b1;
                    if (free_found)
                    begin
                        active_next[free_idx]   = 1'b1;
                        one_shot_next[free_idx] = cmd_reg.one_shot;
                        mem_we                  = 1'b1;
                        mem_waddr               = free_idx;
                        mem_wdata.interval      = cmd_reg.interval_ms;
                        mem_wdata.remaining     = cmd_reg.interval_ms;
                        rsp_next.kind           = KIND_ADDED;
                        rsp_next.slot           = 4'(free_idx);
                    end
                    else
                    begin
                        rsp_next.kind = KIND_FULL;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_WALK:
            begin
                mem_raddr = adv ? IDX_W'(idx_reg + 1'b1) : idx_reg;
                if (adv)
                begin
                    if (fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '0;
                            rsp_next.kind  = KIND_FIRED;
                            rsp_next.slot  = 4'(pend_slot_reg);
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        if (one_shot_reg[idx_reg])
                        begin
                            active_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            mem_wdata.remaining = mem_rdata.interval;
                        end
                    end
                    else if (is_tick && cur_act)
                    begin
                        mem_we              = 1'b1;
                        mem_wdata.remaining = mem_rdata.remaining - 1'b1;
                    end

                    if (!is_tick && cur_act && (!any_reg || mem_rdata.remaining < best_reg))
                    begin
                        any_next  = 1'b1;
                        best_next = mem_rdata.remaining;
                    end

                    if (last_idx)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = IDX_W'(idx_reg + 1'b1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (is_tick && !pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    rsp_next.last  = 1'b1;
                    if (is_tick)
                    begin
                        rsp_next.kind   = KIND_FIRED;
                        rsp_next.slot   = 4'(pend_slot_reg);
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        rsp_next.kind         = KIND_NEXT;
                        rsp_next.remaining_ms = best_reg;
                        rsp_next.any_active   = any_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            one_shot_reg   <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            any_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            one_shot_reg   <= one_shot_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            any_reg        <= any_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pend_slot_reg <= pend_slot_next;
        best_reg      <= best_next;
        rsp_reg       <= rsp_next;
    end

endmodule

FILE: hw/rtl/stp_checker.sv
// Port-level checks for the software timer pool, bound to the top level.
module stp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input stp_pkg::stp_in_t  cmd,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input stp_pkg::stp_out_t rsp
);
    import stp_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd.action != ACT_DELETE |=> !cmd_ready)
        else $error("command taken while previous item still in work");

    a_single_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == KIND_FULL || rsp.kind == KIND_NEXT)
        |-> rsp.slot == 4'd0 && rsp.last)
        else $error("add-full or query answer malformed");

    a_non_query_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind != KIND_NEXT |-> rsp.remaining_ms == '0 && !rsp.any_active)
        else $error("expiry fields set outside query answer");

    a_query_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind == KIND_NEXT && !rsp.any_active |-> rsp.remaining_ms == '0)
        else $error("empty pool reported a remaining time");

endmodule

bind software_timer_pool stp_checker u_stp_checker (.*);

FILE: dv/software_timer_pool_tb.sv
// Self-checking testbench for the software timer pool: directed and random commands.
module software_timer_pool_tb;
    import stp_pkg::*;

    class timer_pool_scoreboard;
        bit                slot_busy[STP_SLOTS];
        bit                slot_once[STP_SLOTS];
        logic [MS_W-1:0]   slot_period[STP_SLOTS];
        logic [MS_W-1:0]   slot_left[STP_SLOTS];
        stp_out_t          expected_results[$];
        int unsigned       n_fail;
        int unsigned       n_checked;

        function new();
            for (int i = 0; i < STP_SLOTS; i++)
            begin
                slot_busy[i]   = 1'b0;
                slot_once[i]   = 1'b0;
                slot_period[i] = '0;
                slot_left[i]   = '0;
            end
            n_fail    = 0;
            n_checked = 0;
        endfunction

        function stp_out_t make_result(logic [1:0] kind, logic [3:0] slot,
                                       logic [MS_W-1:0] rem, logic any, logic fin);
            stp_out_t r;
            r.kind         = kind;
            r.slot         = slot;
            r.remaining_ms = rem;
            r.any_active   = any;
            r.last         = fin;
            return r;
        endfunction

        function int unsigned active_count();
            int unsigned n;
            n = 0;
            foreach (slot_busy[i])
                n += 32'(slot_busy[i]);
            return n;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        // Updates the pool copy for one accepted command and queues its results.
        function void apply_command(stp_in_t c);
            stp_out_t        fired[$];
            stp_out_t        r;
            logic [MS_W-1:0] best;
            bit              found;
            best  = '0;
            found = 1'b0;
            case (c.action)
                ACT_ADD:
                begin
                    for (int i = 0; i < STP_SLOTS; i++)
                    begin
                        if (!found && !slot_busy[i])
                        begin
                            slot_busy[i]   = 1'b1;
                            slot_once[i]   = c.one_shot;
                            slot_period[i] = c.interval_ms;
                            slot_left[i]   = c.interval_ms;
                            found          = 1'b1;
                            expected_results.push_back(
                                make_result(KIND_ADDED, i[3:0], '0, 1'b0, 1'b1));
                        end
                    end
                    if (!found)
                        expected_results.push_back(make_result(KIND_FULL, '0, '0, 1'b0, 1'b1));
                end
                ACT_DELETE:
                begin
                    if (int'(c.slot_id) < STP_SLOTS)
                        slot_busy[c.slot_id] = 1'b0;
                end
                ACT_TICK:
                begin
                    for (int i = 0; i < STP_SLOTS; i++)
                    begin
                        if (slot_busy[i])
                        begin
                            if (slot_left[i] <= 1)
                            begin
                                fired.push_back(make_result(KIND_FIRED, i[3:0], '0, 1'b0, 1'b0));
                                if (slot_once[i])
                                    slot_busy[i] = 1'b0;
                                else
                                    slot_left[i] = slot_period[i];
                            end
                            else
                                slot_left[i] = slot_left[i] - 1'b1;
                        end
                    end
                    if (fired.size() > 0)
                        fired[fired.size()-1].last = 1'b1;
                    foreach (fired[k])
                        expected_results.push_back(fired[k]);
                end
                default:
                begin
                    for (int i = 0; i < STP_SLOTS; i++)
                    begin
                        if (slot_busy[i] && (!found || slot_left[i] < best))
                        begin
                            best  = slot_left[i];
                            found = 1'b1;
                        end
                    end
                    r = make_result(KIND_NEXT, '0, best, found, 1'b1);
                    expected_results.push_back(r);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                n_fail++;
            end
        endfunction

        function void check_response(stp_out_t got);
            stp_out_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with none expected: kind %0d slot %0d", got.kind, got.slot);
                n_fail++;
                return;
            end
            want = expected_results.pop_front();
            n_checked++;
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("slot", 32'(want.slot), 32'(got.slot));
            compare_field("remaining_ms", 32'(want.remaining_ms), 32'(got.remaining_ms));
            compare_field("any_active", 32'(want.any_active), 32'(got.any_active));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_ready;
    stp_in_t  cmd;
    logic     rsp_valid;
    logic     rsp_ready;
    stp_out_t rsp;

    timer_pool_scoreboard pool_sb = new();

    software_timer_pool DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic stp_in_t make_cmd(logic [1:0] act, logic [MS_W-1:0] ivl,
                                         logic once, logic [3:0] sid);
        stp_in_t c;
        c.action      = act;
        c.interval_ms = ivl;
        c.one_shot    = once;
        c.slot_id     = sid;
        return c;
    endfunction

    function automatic logic [MS_W-1:0] pick_interval();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return MS_W'($urandom_range(0, 8));
        if (r < 85)
            return MS_W'($urandom_range(9, 60));
        if (r < 95)
            return MS_W'($urandom_range(0, 24'hFFFFFF));
        return 24'hFFFFFF - MS_W'($urandom_range(0, 3));
    endfunction

    // Valid stays high into the next item when the gap is zero.
    task automatic send_cmd(input stp_in_t c, input int unsigned gap);
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        pool_sb.apply_command(c);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pool_sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_cmd(make_cmd(ACT_QUERY, '0, 1'b0, '0), pick_gap());
        send_cmd(make_cmd(ACT_ADD, 24'd0, 1'b0, 4'd0), pick_gap());
        send_cmd(make_cmd(ACT_ADD, 24'd1, 1'b1, 4'd0), pick_gap());
        send_cmd(make_cmd(ACT_ADD, 24'hFFFFFF, 1'b0, 4'hF), pick_gap());
        send_cmd(make_cmd(ACT_ADD, 24'd2, 1'b1, 4'd0), pick_gap());
        send_cmd(make_cmd(ACT_QUERY, '0, 1'b0, '0), pick_gap());
        send_cmd(make_cmd(ACT_TICK, '0, 1'b0, '0), pick_gap());
        send_cmd(make_cmd(ACT_TICK, 24'hFFFFFF, 1'b1, 4'hF), pick_gap());
        send_cmd(make_cmd(ACT_DELETE, '0, 1'b0, 4'd5), pick_gap());
        send_cmd(make_cmd(ACT_DELETE, '0, 1'b0, 4'd15), pick_gap());
        for (int i = 0; i < 14; i++)
            send_cmd(make_cmd(ACT_ADD, MS_W'($urandom_range(3, 30)),
                              1'($urandom_range(0, 1)), '0),
                     pick_gap());
        send_cmd(make_cmd(ACT_ADD, 24'd5, 1'b0, '0), pick_gap());
        send_cmd(make_cmd(ACT_DELETE, '0, 1'b0, 4'd2), pick_gap());
        send_cmd(make_cmd(ACT_QUERY, '0, 1'b0, '0), pick_gap());
    endtask

    task automatic run_random(input int unsigned count);
        stp_in_t     c;
        int unsigned r;
        int unsigned del_pct;
        int unsigned gap;
        for (int unsigned n = 0; n < count; n++)
        begin
            c.interval_ms = MS_W'($urandom_range(0, 24'hFFFFFF));
            c.one_shot    = 1'($urandom_range(0, 1));
            c.slot_id     = 4'($urandom_range(0, 15));
            del_pct       = (pool_sb.active_count() >= 14) ? 35 : 12;
            r             = $urandom_range(0, 99);
            if (r < 30)
            begin
                c.action      = ACT_ADD;
                c.interval_ms = pick_interval();
            end
            else if (r < 30 + del_pct)
                c.action = ACT_DELETE;
            else if (r < 85)
                c.action = ACT_TICK;
            else
                c.action = ACT_QUERY;
            gap = ((n / 40) % 3 == 1) ? 0 : pick_gap();
            send_cmd(c, gap);
            if (n == count / 2)
                drain_results();
        end
    endtask

    // Response side: random stalls, a quiet window, and one long hold-off.
    initial
    begin
        int unsigned stall_left;
        int unsigned cyc;
        bit          held;
        stall_left = 0;
        cyc        = 0;
        held       = 1'b0;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rsp_valid && rsp_ready)
                pool_sb.check_response(rsp);
            if (!held && pool_sb.n_checked >= 90)
            begin
                held       = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (cyc[9:8] != 2'b01)
                    stall_left = pick_gap();
                rsp_ready <= (stall_left == 0);
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain_results();
        run_random(305);
        drain_results();
        repeat (2 * STP_SLOTS + 8) @(posedge clk);
        if (pool_sb.n_fail == 0 && pool_sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
